### rtl/core/rrcp_pkg.sv
`timescale 1ns / 1ps

package rrcp_pkg;

    // Table geometry.
    localparam int MAX_SEATS = 32;
    localparam int MAX_PAIRS = MAX_SEATS / 2;
    localparam int SEAT_W    = $clog2(MAX_SEATS);
    localparam int COUNT_W   = 6;
    localparam int LEN_W     = 5;
    localparam int TABLE_W   = 4;

    // Payload widths.
    localparam int PLAYER_W  = 16;
    localparam int ROUND_W   = 16;
    localparam int STEP_W    = $clog2(ROUND_W);

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_ROUND = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_EMIT
    } state_t;

    // Divider control and status.
    typedef struct packed {
        logic                start;
        logic [ROUND_W-1:0]  dividend;
        logic [LEN_W-1:0]    divisor;
    } div_ctl_t;

    typedef struct packed {
        logic                done;
        logic [LEN_W-1:0]    rem;
        logic                q_lsb;
    } div_sts_t;

    // Seat that holds the player seen at ring index m once the ring is
    // rotated by the round remainder. The ring runs 1..k-1 and then
    // 2k-1 down to k.
    function automatic logic [SEAT_W-1:0] ring_src(
        input logic [LEN_W-1:0] m,
        input logic [LEN_W-1:0] rem,
        input logic [LEN_W-1:0] len,
        input logic [LEN_W-1:0] k
    );
        logic [LEN_W:0]   sum;
        logic [LEN_W:0]   pos;
        logic [LEN_W:0]   km1;
        logic [LEN_W+1:0] far;
        logic [SEAT_W-1:0] seat;
        sum = {1'b0, m} + {1'b0, rem};
        pos = (sum >= {1'b0, len}) ? (sum - {1'b0, len}) : sum;
        km1 = {1'b0, k} - (LEN_W+1)'(1);
        far = ({2'b00, k} << 1) + {2'b00, k} - (LEN_W+2)'(2) - {1'b0, pos};
        if (pos < km1)
        begin
            seat = SEAT_W'(pos + (LEN_W+1)'(1));
        end
        else
        begin
            seat = SEAT_W'(far);
        end
        return seat;
    endfunction

endpackage

### rtl/core/rrcp_if.sv
`timescale 1ns / 1ps

// Command channel: seat writes and round requests.
interface rrcp_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [rrcp_pkg::SEAT_W-1:0]   seat_index;
    logic [rrcp_pkg::PLAYER_W-1:0] player_id;
    logic                          seat_is_bye;
    logic [rrcp_pkg::ROUND_W-1:0]  round_number;

    modport source (output valid, kind, seat_index, player_id, seat_is_bye, round_number,
                    input ready);
    modport sink   (input valid, kind, seat_index, player_id, seat_is_bye, round_number,
                    output ready);
endinterface

// Pair channel: one transfer per pairing result.
interface rrcp_pair_if;
    logic                          valid;
    logic                          ready;
    logic [rrcp_pkg::PLAYER_W-1:0] black_player;
    logic [rrcp_pkg::PLAYER_W-1:0] white_player;
    logic [rrcp_pkg::TABLE_W-1:0]  table_index;
    logic                          last;
    logic                          error;

    modport source (output valid, black_player, white_player, table_index, last, error,
                    input ready);
    modport sink   (input valid, black_player, white_player, table_index, last, error,
                    output ready);
endinterface

// Configuration channel: the seat count register.
interface rrcp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rrcp_pkg::COUNT_W-1:0] seat_count;

    modport source (output valid, seat_count, input ready);
    modport sink   (input valid, seat_count, output ready);
endinterface

### rtl/core/rrcp_ram.sv
`timescale 1ns / 1ps

// Generic RAM: one write port, two read ports with registered data.
module rrcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports hold their data while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### rtl/core/rrcp_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Gives the remainder and
// the least significant quotient bit of the round number over the ring length.
module rrcp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rrcp_pkg::div_ctl_t ctl,
    output rrcp_pkg::div_sts_t sts
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rrcp_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [rrcp_pkg::ROUND_W-1:0]  dvd_reg, dvd_next;
    logic [rrcp_pkg::LEN_W-1:0]    rem_reg, rem_next;
    logic [rrcp_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                          q_reg, q_next;
    logic [rrcp_pkg::LEN_W:0]      shifted;
    logic [rrcp_pkg::LEN_W:0]      diff;
    logic                          fits;

    // One step: shift in the next dividend bit, subtract when it fits.
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[rrcp_pkg::ROUND_W-1]};
        diff      = shifted - {1'b0, len_reg};
        fits      = (shifted >= {1'b0, len_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        q_next    = q_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = ctl.dividend;
            rem_next  = '0;
            len_next  = ctl.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[rrcp_pkg::LEN_W-1:0] : shifted[rrcp_pkg::LEN_W-1:0];
            dvd_next = dvd_reg << 1;
            q_next   = fits;
            cnt_next = rrcp_pkg::STEP_W'(cnt_reg + 1'b1);
            if (cnt_reg == rrcp_pkg::STEP_W'(rrcp_pkg::ROUND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        len_reg <= len_next;
        q_reg   <= q_next;
    end

    assign sts.done  = done_reg;
    assign sts.rem   = rem_reg;
    assign sts.q_lsb = q_reg;

endmodule

### rtl/core/round_robin_circle_pairing_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload
// cfg      in         seat_count (6)
// cmd      in         kind, seat_index (5), player_id (16), seat_is_bye, round_number (16)
// pair     out        black_player (16), white_player (16), table_index (4), last, error
//
// A seat write gives no result.
// A round request runs through the shared bit-serial divider, then reads the seats
// of each pair through the two read ports of the seat RAM.
// An invalid seat count passes through the error state to its single error result.
// Reset clears the control state and the bye flag; the seat table is not cleared.
// A stall on pair holds the result register and the RAM read data; cmd is
// taken again as soon as the last pair of a request sits in the result register.
module round_robin_circle_pairing_core (
    input  logic              clk,
    input  logic              rst_n,
    rrcp_cfg_if.sink          cfg,
    rrcp_cmd_if.sink          cmd,
    rrcp_pair_if.source       pair
);

    rrcp_pkg::state_t              state_reg, state_next;
    logic [rrcp_pkg::COUNT_W-1:0]  count_reg;
    logic                          bye_reg, bye_next;
    logic                          r0_reg, r0_next;
    logic [rrcp_pkg::TABLE_W-1:0]  tbl_reg, tbl_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_err_reg, s1_err_next;
    logic                          s1_swap_reg, s1_swap_next;
    logic                          s1_last_reg, s1_last_next;
    logic [rrcp_pkg::TABLE_W-1:0]  s1_tbl_reg, s1_tbl_next;

    rrcp_pkg::div_ctl_t            div_ctl;
    rrcp_pkg::div_sts_t            div_sts;

    logic [rrcp_pkg::LEN_W-1:0]    k_w;
    logic [rrcp_pkg::LEN_W-1:0]    len_w;
    logic                          count_ok;
    logic                          slot_free;
    logic                          last_w;
    logic                          swap_w;
    logic [rrcp_pkg::LEN_W-1:0]    m_a;
    logic [rrcp_pkg::LEN_W-1:0]    m_b;
    logic [rrcp_pkg::SEAT_W-1:0]   addr_a;
    logic [rrcp_pkg::SEAT_W-1:0]   addr_b;
    logic                          ram_we;
    logic                          ram_re;
    logic [rrcp_pkg::PLAYER_W-1:0] rd_a;
    logic [rrcp_pkg::PLAYER_W-1:0] rd_b;

    // Configuration register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            count_reg <= cfg.seat_count;
        end
    end

    // Table geometry from the seat count.
    assign k_w      = count_reg[rrcp_pkg::COUNT_W-1:1];
    assign len_w    = rrcp_pkg::LEN_W'(count_reg - 1'b1);
    assign count_ok = (count_reg >= rrcp_pkg::COUNT_W'(2)) && !count_reg[0]
                      && (count_reg <= rrcp_pkg::COUNT_W'(rrcp_pkg::MAX_SEATS));

    // Seats read for the current table: seat i against seat i+k, which sits at
    // ring index 2k-2-i. The pivot pairs seat 0 with seat k, the last ring index.
    always_comb
    begin
        if (tbl_reg == '0)
        begin
            m_a    = '0;
            addr_a = '0;
        end
        else
        begin
            m_a    = rrcp_pkg::LEN_W'(tbl_reg - 1'b1);
            addr_a = rrcp_pkg::ring_src(m_a, div_sts.rem, len_w, k_w);
        end
        m_b    = rrcp_pkg::LEN_W'(({1'b0, k_w} << 1) - (rrcp_pkg::LEN_W+1)'(2)
                 - {2'b00, tbl_reg});
        addr_b = rrcp_pkg::ring_src(m_b, div_sts.rem, len_w, k_w);
    end

    assign last_w    = ({1'b0, tbl_reg} == rrcp_pkg::LEN_W'(k_w - 1'b1));
    assign swap_w    = (tbl_reg == '0) ? r0_reg : (tbl_reg[0] ^ div_sts.q_lsb);
    assign slot_free = !s1_valid_reg || pair.ready;

    // Sequencer: next state, table counter and result stage.
    always_comb
    begin
        state_next       = state_reg;
        bye_next         = bye_reg;
        r0_next          = r0_reg;
        tbl_next         = tbl_reg;
        s1_valid_next    = s1_valid_reg;
        s1_err_next      = s1_err_reg;
        s1_swap_next     = s1_swap_reg;
        s1_last_next     = s1_last_reg;
        s1_tbl_next      = s1_tbl_reg;
        div_ctl.start    = 1'b0;
        div_ctl.dividend = cmd.round_number;
        div_ctl.divisor  = len_w;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        cmd.ready        = (state_reg == rrcp_pkg::ST_IDLE);

        if (s1_valid_reg && pair.ready)
        begin
            s1_valid_next = 1'b0;
        end

        case (state_reg)
            rrcp_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.kind == rrcp_pkg::KIND_WRITE)
                    begin
                        ram_we = 1'b1;
                        if (cmd.seat_index == '0)
                        begin
                            bye_next = cmd.seat_is_bye;
                        end
                    end
                    else if (!count_ok)
                    begin
                        state_next = rrcp_pkg::ST_ERR;
                    end
                    else
                    begin
                        div_ctl.start = 1'b1;
                        r0_next       = cmd.round_number[0];
                        state_next    = rrcp_pkg::ST_DIV;
                    end
                end
            end
            rrcp_pkg::ST_DIV:
            begin
                if (div_sts.done)
                begin
                    if ((k_w == rrcp_pkg::LEN_W'(1)) && bye_reg)
                    begin
                        state_next = rrcp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        tbl_next   = bye_reg ? rrcp_pkg::TABLE_W'(1) : '0;
                        state_next = rrcp_pkg::ST_EMIT;
                    end
                end
            end
            rrcp_pkg::ST_ERR:
            begin
                if (slot_free)
                begin
                    s1_valid_next = 1'b1;
                    s1_err_next   = 1'b1;
                    s1_swap_next  = 1'b0;
                    s1_last_next  = 1'b1;
                    s1_tbl_next   = '0;
                    state_next    = rrcp_pkg::ST_IDLE;
                end
            end
            rrcp_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    ram_re        = 1'b1;
                    s1_valid_next = 1'b1;
                    s1_err_next   = 1'b0;
                    s1_swap_next  = swap_w;
                    s1_last_next  = last_w;
                    s1_tbl_next   = tbl_reg;
                    tbl_next      = rrcp_pkg::TABLE_W'(tbl_reg + 1'b1);
                    if (last_w)
                    begin
                        state_next = rrcp_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rrcp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rrcp_pkg::ST_IDLE;
            bye_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bye_reg      <= bye_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        r0_reg      <= r0_next;
        tbl_reg     <= tbl_next;
        s1_err_reg  <= s1_err_next;
        s1_swap_reg <= s1_swap_next;
        s1_last_reg <= s1_last_next;
        s1_tbl_reg  <= s1_tbl_next;
    end

    // Shared divider for the round remainder and parity of the quotient.
    rrcp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    // Seat table.
    rrcp_ram #(
        .WIDTH (rrcp_pkg::PLAYER_W),
        .DEPTH (rrcp_pkg::MAX_SEATS)
    ) u_seat_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (cmd.seat_index),
        .wdata   (cmd.player_id),
        .re      (ram_re),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Result outputs.
    assign pair.valid        = s1_valid_reg;
    assign pair.black_player = s1_err_reg ? '0 : (s1_swap_reg ? rd_b : rd_a);
    assign pair.white_player = s1_err_reg ? '0 : (s1_swap_reg ? rd_a : rd_b);
    assign pair.table_index  = s1_tbl_reg;
    assign pair.last         = s1_last_reg;
    assign pair.error        = s1_err_reg;

`ifndef SYNTHESIS
    // An error result is always alone: last set and table zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.error) |-> (pair.last && (pair.table_index == '0)))
        else $error("error result without last or with nonzero table");

    // A request on a valid table starts the divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (cmd.kind == rrcp_pkg::KIND_ROUND) && count_ok)
        |=> (state_reg == rrcp_pkg::ST_DIV))
        else $error("round request did not start the divider");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == rrcp_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    // The seat table is not read while an unaccepted result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !pair.ready) |-> !ram_re)
        else $error("seat RAM read during a stalled result");
`endif

endmodule
